@@ rtl/pita_pkg.sv @@
`default_nettype none

package pita_pkg;

    // Tile buffer geometry
    localparam int TILE_ROWS = 16;
    localparam int TILE_COLS = 16;
    localparam int LANES     = 8;
    localparam int IN_ROWS   = 32;
    localparam int IN_COLS   = 32;

    // Field widths
    localparam int ROW_W   = 10;
    localparam int CHAN_W  = 10;
    localparam int LANE_W  = 3;
    localparam int BUF_W   = 5;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Signed coordinate and positive dimension widths
    localparam int COORD_W = 15;
    localparam int DIM_W   = 13;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [KIND_W-1:0] {
        FILL_LEAVE = 2'd0,
        FILL_ZERO  = 2'd1,
        FILL_FETCH = 2'd2
    } t_fill_kind;

    typedef enum logic [2:0] {
        REG_IN_BASE       = 3'd0,
        REG_CHANNEL_COUNT = 3'd1,
        REG_KERNEL_SIZE   = 3'd2,
        REG_STRIDE        = 3'd3,
        REG_OUT_ROWS      = 3'd4,
        REG_OUT_COLS      = 3'd5,
        REG_PADDING_ON    = 3'd6
    } t_reg_idx;

endpackage

`default_nettype wire

@@ rtl/pita_in_if.sv @@
`default_nettype none

interface pita_in_if import pita_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  tile_row;
    logic [ROW_W-1:0]  tile_col;
    logic [CHAN_W-1:0] chan_base;
    logic [LANE_W-1:0] lane;
    logic [BUF_W-1:0]  buf_row;
    logic [BUF_W-1:0]  buf_col;

    modport source (
        output valid, tile_row, tile_col, chan_base, lane, buf_row, buf_col,
        input  ready
    );

    modport sink (
        input  valid, tile_row, tile_col, chan_base, lane, buf_row, buf_col,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/pita_out_if.sv @@
`default_nettype none

interface pita_out_if import pita_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] fill_kind;
    logic [ADDR_W-1:0] address;

    modport source (
        output valid, fill_kind, address,
        input  ready
    );

    modport sink (
        input  valid, fill_kind, address,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/padded_input_tile_address_top.sv @@
`default_nettype none

// Source address generator for a convolution input tile buffer. Each input
// transaction names one buffer element (lane, buf_row, buf_col) of the tile at
// output origin (tile_row, tile_col) and channel group chan_base; the output
// transaction says whether to leave the entry (fill_kind 0), write zero (1) or
// fetch from the given 32-bit word address (2). The block takes one transaction
// per cycle while the output is not stalled, and carries each one through four
// register stages: source coordinates and map extents, classification with the
// first products, the channel-plane product, and the final address add. Each
// stage holds only while the one after it is full and stalled, so bubbles are
// squeezed out under backpressure. Program the APB registers (byte address
// 4*index: in_base, channel_count, kernel_size, stride, out_rows, out_cols,
// padding_on) only while no transactions are in flight.
module padded_input_tile_address_top import pita_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pita_in_if.sink            i_in,
    pita_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Configuration registers
    logic [ADDR_W-1:0] r_in_base;
    logic [CHAN_W-1:0] r_channel_count;
    logic [3:0]        r_kernel_size;
    logic [2:0]        r_stride;
    logic [ROW_W-1:0]  r_out_rows;
    logic [ROW_W-1:0]  r_out_cols;
    logic              r_padding_on;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    // Write configuration on the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base       <= '0;
            r_channel_count <= CHAN_W'(1);
            r_kernel_size   <= 4'd1;
            r_stride        <= 3'd1;
            r_out_rows      <= ROW_W'(1);
            r_out_cols      <= ROW_W'(1);
            r_padding_on    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IN_BASE:       r_in_base       <= pwdata;
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CHAN_W-1:0];
                REG_KERNEL_SIZE:   r_kernel_size   <= pwdata[3:0];
                REG_STRIDE:        r_stride        <= pwdata[2:0];
                REG_OUT_ROWS:      r_out_rows      <= pwdata[ROW_W-1:0];
                REG_OUT_COLS:      r_out_cols      <= pwdata[ROW_W-1:0];
                REG_PADDING_ON:    r_padding_on    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        unique case (cfg_idx)
            REG_IN_BASE:       prdata = r_in_base;
            REG_CHANNEL_COUNT: prdata = PDATA_W'(r_channel_count);
            REG_KERNEL_SIZE:   prdata = PDATA_W'(r_kernel_size);
            REG_STRIDE:        prdata = PDATA_W'(r_stride);
            REG_OUT_ROWS:      prdata = PDATA_W'(r_out_rows);
            REG_OUT_COLS:      prdata = PDATA_W'(r_out_cols);
            REG_PADDING_ON:    prdata = PDATA_W'(r_padding_on);
            default:           prdata = '0;
        endcase
    end

    // Pipeline valid bits and per-stage ready
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4       = !r_v4 || o_out.ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage 1: kernel offsets, tile extent, map size and source coordinates
    logic [2:0]         c_half;
    logic [3:0]         c_ext;
    logic [DIM_W-1:0]   c_trow_s;
    logic [DIM_W-1:0]   c_tcol_s;
    logic [COORD_W-1:0] c_ty, c_tx, c_h, c_w, c_y, c_x;
    logic [CHAN_W:0]    c_n;
    logic               c_outside;

    always_comb begin
        c_half    = (r_padding_on && r_kernel_size != 4'd0) ?
                    3'((r_kernel_size - 4'd1) >> 1) : 3'd0;
        c_ext     = r_padding_on ? 4'd1 : r_kernel_size;
        c_trow_s  = DIM_W'(i_in.tile_row) * DIM_W'(r_stride);
        c_tcol_s  = DIM_W'(i_in.tile_col) * DIM_W'(r_stride);
        c_ty      = (COORD_W'(i_in.tile_row) + COORD_W'(TILE_ROWS - 1))
                    * COORD_W'(r_stride) + COORD_W'(c_ext);
        c_tx      = (COORD_W'(i_in.tile_col) + COORD_W'(TILE_COLS - 1))
                    * COORD_W'(r_stride) + COORD_W'(c_ext);
        c_h       = COORD_W'(r_out_rows) * COORD_W'(r_stride)
                    - COORD_W'(r_stride) + COORD_W'(c_ext);
        c_w       = COORD_W'(r_out_cols) * COORD_W'(r_stride)
                    - COORD_W'(r_stride) + COORD_W'(c_ext);
        c_y       = COORD_W'(i_in.buf_row) + COORD_W'(c_trow_s) - COORD_W'(c_half);
        c_x       = COORD_W'(i_in.buf_col) + COORD_W'(c_tcol_s) - COORD_W'(c_half);
        c_n       = (CHAN_W+1)'(i_in.chan_base) + (CHAN_W+1)'(i_in.lane);
        c_outside = (int'(i_in.lane) >= LANES) || (int'(i_in.buf_row) >= IN_ROWS)
                    || (int'(i_in.buf_col) >= IN_COLS);
    end

    t_coord          r1_ty, r1_tx, r1_h, r1_w, r1_y, r1_x;
    logic [CHAN_W:0] r1_n;
    logic            r1_outside;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in.valid) begin
            r1_ty      <= t_coord'(c_ty);
            r1_tx      <= t_coord'(c_tx);
            r1_h       <= t_coord'(c_h);
            r1_w       <= t_coord'(c_w);
            r1_y       <= t_coord'(c_y);
            r1_x       <= t_coord'(c_x);
            r1_n       <= c_n;
            r1_outside <= c_outside;
        end
    end

    // Stage 2: classify the element, form channel-plane and row products
    t_fill_kind n_kind2;

    always_comb begin
        if (r1_outside || r1_y >= r1_ty || r1_x >= r1_tx) begin
            n_kind2 = FILL_LEAVE;
        end else if (r1_n >= (CHAN_W+1)'(r_channel_count) || r1_y[COORD_W-1]
                     || r1_x[COORD_W-1] || r1_y >= r1_h || r1_x >= r1_w) begin
            n_kind2 = FILL_ZERO;
        end else begin
            n_kind2 = FILL_FETCH;
        end
    end

    t_fill_kind       r2_kind;
    logic [23:0]      r2_nh;
    logic [25:0]      r2_yw;
    logic [DIM_W-1:0] r2_w;
    logic [DIM_W-1:0] r2_x;

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r2_kind <= n_kind2;
            r2_nh   <= 24'(r1_n) * 24'(r1_h[DIM_W-1:0]);
            r2_yw   <= 26'(r1_y[DIM_W-1:0]) * 26'(r1_w[DIM_W-1:0]);
            r2_w    <= r1_w[DIM_W-1:0];
            r2_x    <= r1_x[DIM_W-1:0];
        end
    end

    // Stage 3: channel-plane offset and base plus row/column offset
    t_fill_kind        r3_kind;
    logic [ADDR_W-1:0] r3_nhw;
    logic [ADDR_W-1:0] r3_part;

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r3_kind <= r2_kind;
            r3_nhw  <= ADDR_W'(r2_nh) * ADDR_W'(r2_w);
            r3_part <= r_in_base + ADDR_W'(r2_yw) + ADDR_W'(r2_x);
        end
    end

    // Stage 4: final address, zero unless fetching
    t_fill_kind        r4_kind;
    logic [ADDR_W-1:0] r4_address;
    logic [ADDR_W-1:0] n_address;

    assign n_address = (r3_kind == FILL_FETCH) ? (r3_nhw + r3_part) : '0;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            r4_kind    <= r3_kind;
            r4_address <= n_address;
        end
    end

    assign o_out.valid     = r_v4;
    assign o_out.fill_kind = r4_kind;
    assign o_out.address   = r4_address;

    // Checks
    a_addr_zero_unless_fetch: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.fill_kind != FILL_FETCH) |-> o_out.address == '0
    ) else $error("nonzero address on a non-fetch transaction");

    a_stall_only_from_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready)
    ) else $error("input stalled without output backpressure");

    a_stage3_drains: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4) |=> r_v4
    ) else $error("stage 3 transaction lost on its way to the output");

endmodule

`default_nettype wire
